FILE: rtl/core/amt_pkg.sv
// ----------------------------------------------------------------------------
// amt_pkg
// Shared types and constants for the adaptive mean threshold core.
// ----------------------------------------------------------------------------
package amt_pkg;

  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_MAX_ROWS   = 4096;
  localparam int DEF_MAX_RADIUS = 7;

  localparam int PIX_W  = 8;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 13;
  localparam int FW_W   = 11;
  localparam int FH_W   = 13;
  localparam int RAD_W  = 3;
  localparam int OFF_W  = 10;
  localparam int K_W    = 10;

  localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IW-1:0] REG_RADIUS = 2'd2;
  localparam logic [CFG_IW-1:0] REG_OFFSET = 2'd3;

  localparam logic [FW_W-1:0]  RST_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0]  RST_HEIGHT = 13'd480;
  localparam logic [RAD_W-1:0] RST_RADIUS = 3'd5;
  localparam logic [OFF_W-1:0] RST_OFFSET = 10'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CTR,
    S_WAIT,
    S_MUL,
    S_OUT
  } amt_state_t;

  // control that travels down the multiplier chain beside the data
  typedef struct packed {
    logic valid;
    logic force_one;
    logic eof;
  } amt_ctl_t;

endpackage

FILE: rtl/core/amt_line_store.sv
// ----------------------------------------------------------------------------
// amt_line_store
// Row store of recent pixels, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module amt_line_store import amt_pkg::*; #(
  parameter int ROWS = 3 * DEF_MAX_RADIUS + 1,
  parameter int COLS = DEF_MAX_COLS
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(ROWS)-1:0]  wr_row,
  input  logic [$clog2(COLS)-1:0]  wr_col,
  input  logic [PIX_W-1:0]         wr_data,
  input  logic [$clog2(ROWS)-1:0]  rd_row,
  input  logic [$clog2(COLS)-1:0]  rd_col,
  output logic [PIX_W-1:0]         rd_data
);

  logic [PIX_W-1:0] mem [ROWS][COLS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row][wr_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_row][rd_col];
  end

endmodule

FILE: rtl/core/amt_mul_cell.sv
// ----------------------------------------------------------------------------
// amt_mul_cell
// One shift-add step of the threshold product k * window_count.
// ----------------------------------------------------------------------------
module amt_mul_cell import amt_pkg::*; #(
  parameter int IDX   = 0,
  parameter int NW    = 8,
  parameter int SUM_W = 16,
  parameter int PW    = 18
) (
  input  logic             clk,
  input  logic             rst_n,
  input  amt_ctl_t         ctl_i,
  input  logic [K_W-1:0]   k_i,
  input  logic [NW-1:0]    n_i,
  input  logic [SUM_W-1:0] sum_i,
  input  logic [PW-1:0]    acc_i,
  output amt_ctl_t         ctl_o,
  output logic [K_W-1:0]   k_o,
  output logic [NW-1:0]    n_o,
  output logic [SUM_W-1:0] sum_o,
  output logic [PW-1:0]    acc_o
);

  logic [PW-1:0] addend;

  assign addend = n_i[IDX] ? (PW'(k_i) << IDX) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_o <= '0;
    end else begin
      ctl_o <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    k_o   <= k_i;
    n_o   <= n_i;
    sum_o <= sum_i;
    acc_o <= acc_i + addend;
  end

endmodule

FILE: rtl/core/adaptive_mean_threshold_core.sv
// ----------------------------------------------------------------------------
// adaptive_mean_threshold_core
// Inverted binary threshold of a raster pixel stream against its local mean.
// ----------------------------------------------------------------------------
// Pixels are written into a row store as they arrive; each item that makes a
// result triggers a scan of the (2R+1)^2 window through the single store read
// port, one pixel per cycle, then a center read and a chain of shift-add cells
// that checks (center + offset + 1) * count <= window sum. An item that makes
// a result holds off further items while the store read port and the chain of
// NW cells form it (NW = bits of the largest window count); any other item does
// not. Results lag the input by R rows plus R pixels; feed flush items (tuser
// high) after the frame to drain them. A config write restarts the frame.
module adaptive_mean_threshold_core import amt_pkg::*; #(
  parameter int MAX_COLS   = DEF_MAX_COLS,
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] pixel
  input  logic              in_tuser,   // [0] flush
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [0] binary_pixel, rest zero
  output logic              out_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int CW    = $clog2(MAX_COLS);
  localparam int WW    = $clog2(MAX_COLS + 1);
  localparam int HW    = $clog2(MAX_ROWS + 1);
  localparam int SR    = 3 * MAX_RADIUS + 1;
  localparam int SRW   = $clog2(SR);
  localparam int ROW_W = $clog2(MAX_ROWS + MAX_RADIUS + 1);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int OW    = RW + 1;
  localparam int NW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int SUM_W = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) * 255 + 1);
  localparam int CNT_W = $clog2(MAX_COLS * (MAX_ROWS + MAX_RADIUS + 1) + 1);
  localparam int PW    = K_W + NW;
  localparam int YW    = ROW_W + 2;
  localparam int XW    = CW + 2;

  amt_state_t state_r, state_nxt;

  logic [FW_W-1:0]  cfg_w_r;
  logic [FH_W-1:0]  cfg_h_r;
  logic [RAD_W-1:0] cfg_rad_r;
  logic [OFF_W-1:0] cfg_off_r;

  logic [CW-1:0]    in_col_r;
  logic [ROW_W-1:0] in_row_r;
  logic [SRW-1:0]   in_srow_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CW-1:0]    out_col_r;
  logic [ROW_W-1:0] out_row_r;
  logic [SRW-1:0]   out_srow_r;
  logic signed [OW-1:0] m_r, n_r;
  logic [SUM_W-1:0] sum_r;
  logic             acc_en_r;
  logic             res_bit_r, res_eof_r;
  logic             out_valid_r, out_bit_r, out_last_r;

  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [RW-1:0]    rad;
  logic signed [OW-1:0] rad_s;
  logic [CNT_W-1:0] lead;
  logic [NW-1:0]    nwin;

  logic             in_acc, in_live, in_adv, restart;
  logic             scan_issue, scan_done, launch, out_load;
  logic [PIX_W-1:0] rd_data;
  logic [SRW-1:0]   rd_row;
  logic [CW-1:0]    rd_col;

  amt_ctl_t         ctl_c [NW+1];
  logic [K_W-1:0]   k_c   [NW+1];
  logic [NW-1:0]    n_c   [NW+1];
  logic [SUM_W-1:0] sum_c [NW+1];
  logic [PW-1:0]    acc_c [NW+1];

  // effective (clamped) settings
  always_comb begin
    if (cfg_w_r == '0)                  w_eff = WW'(1);
    else if (32'(cfg_w_r) > MAX_COLS)   w_eff = WW'(MAX_COLS);
    else                                w_eff = WW'(cfg_w_r);
    if (cfg_h_r == '0)                  h_eff = HW'(1);
    else if (32'(cfg_h_r) > MAX_ROWS)   h_eff = HW'(MAX_ROWS);
    else                                h_eff = HW'(cfg_h_r);
    if (32'(cfg_rad_r) > MAX_RADIUS)    rad = RW'(MAX_RADIUS);
    else                                rad = RW'(cfg_rad_r);
  end

  assign rad_s = $signed({1'b0, rad});
  assign lead  = CNT_W'(rad) * CNT_W'(w_eff) + CNT_W'(rad);
  assign nwin  = NW'({rad, 1'b1}) * NW'({rad, 1'b1});

  // config port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r   <= RST_WIDTH;
      cfg_h_r   <= RST_HEIGHT;
      cfg_rad_r <= RST_RADIUS;
      cfg_off_r <= RST_OFFSET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  cfg_w_r   <= cfg_data[FW_W-1:0];
        REG_HEIGHT: cfg_h_r   <= cfg_data[FH_W-1:0];
        REG_RADIUS: cfg_rad_r <= cfg_data[RAD_W-1:0];
        REG_OFFSET: cfg_off_r <= cfg_data[OFF_W-1:0];
        default: ;
      endcase
    end
  end

  // input side
  assign in_acc  = in_tvalid && in_tready;
  assign in_live = (32'(in_row_r) < 32'(h_eff));
  // a flush while pixels are still expected is dropped
  assign in_adv  = in_acc && !(in_live && in_tuser);

  // window scan coordinates with edge replication
  logic signed [YW-1:0] ysum, ycl, dy, srow_full;
  logic signed [XW-1:0] xsum, xcl;

  always_comb begin
    ysum = $signed({2'b0, out_row_r}) + YW'(m_r);
    if (ysum < 0)                         ycl = '0;
    else if (ysum > YW'(h_eff) - YW'(1))  ycl = YW'(h_eff) - YW'(1);
    else                                  ycl = ysum;
    dy = ycl - $signed({2'b0, out_row_r});
    srow_full = YW'($signed({1'b0, out_srow_r})) + dy;
    if (srow_full < 0)                    srow_full = srow_full + YW'(SR);
    else if (srow_full >= YW'(SR))        srow_full = srow_full - YW'(SR);
    xsum = $signed({2'b0, out_col_r}) + XW'(n_r);
    if (xsum < 0)                         xcl = '0;
    else if (xsum > XW'(w_eff) - XW'(1))  xcl = XW'(w_eff) - XW'(1);
    else                                  xcl = xsum;
  end

  always_comb begin
    if (state_r == S_CTR) begin
      rd_row = out_srow_r;
      rd_col = out_col_r;
    end else begin
      rd_row = srow_full[SRW-1:0];
      rd_col = xcl[CW-1:0];
    end
  end

  amt_line_store #(
    .ROWS (SR),
    .COLS (MAX_COLS)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_adv && in_live),
    .wr_row  (in_srow_r),
    .wr_col  (in_col_r),
    .wr_data (in_tdata),
    .rd_row  (rd_row),
    .rd_col  (rd_col),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_adv && cnt_r >= lead) state_nxt = S_SCAN;
      S_SCAN: if (scan_done) state_nxt = S_CTR;
      S_CTR:  state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_MUL;
      S_MUL:  if (ctl_c[NW].valid) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready  = 1'b0;
    scan_issue = 1'b0;
    launch     = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: in_tready  = 1'b1;
      S_SCAN: scan_issue = 1'b1;
      S_WAIT: launch     = 1'b1;
      S_OUT:  out_load   = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  assign scan_done = (m_r == rad_s) && (n_r == rad_s);
  assign restart   = cfg_valid || (out_load && res_eof_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else if (cfg_valid) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // positions
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_srow_r  <= '0;
      cnt_r      <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_srow_r <= '0;
    end else begin
      if (in_adv) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (32'(in_col_r) + 1 >= 32'(w_eff)) begin
          in_col_r  <= '0;
          in_row_r  <= in_row_r + ROW_W'(1);
          in_srow_r <= (32'(in_srow_r) == SR - 1) ? '0 : in_srow_r + SRW'(1);
        end else begin
          in_col_r <= in_col_r + CW'(1);
        end
      end
      if (out_load) begin
        if (32'(out_col_r) + 1 >= 32'(w_eff)) begin
          out_col_r  <= '0;
          out_row_r  <= out_row_r + ROW_W'(1);
          out_srow_r <= (32'(out_srow_r) == SR - 1) ? '0 : out_srow_r + SRW'(1);
        end else begin
          out_col_r <= out_col_r + CW'(1);
        end
      end
    end
  end

  // window walk and sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      m_r   <= -rad_s;
      n_r   <= -rad_s;
      sum_r <= '0;
    end else begin
      if (scan_issue) begin
        if (n_r == rad_s) begin
          n_r <= -rad_s;
          m_r <= m_r + OW'(1);
        end else begin
          n_r <= n_r + OW'(1);
        end
      end
      if (acc_en_r) sum_r <= sum_r + SUM_W'(rd_data);
    end
  end

  // center + offset + 1 against the mean, without division
  logic signed [K_W:0] k_full;
  amt_ctl_t            ctl_0;

  assign k_full = $signed({3'b0, rd_data}) + (K_W+1)'($signed(cfg_off_r)) + (K_W+1)'(1);

  always_comb begin
    ctl_0.valid     = launch;
    ctl_0.force_one = (k_full <= 0);
    ctl_0.eof       = (32'(out_row_r) == 32'(h_eff) - 1) &&
                      (32'(out_col_r) == 32'(w_eff) - 1);
  end

  assign ctl_c[0] = ctl_0;
  assign k_c[0]   = k_full[K_W-1:0];
  assign n_c[0]   = nwin;
  assign sum_c[0] = sum_r;
  assign acc_c[0] = '0;

  for (genvar i = 0; i < NW; i++) begin : g_cell
    amt_mul_cell #(
      .IDX   (i),
      .NW    (NW),
      .SUM_W (SUM_W),
      .PW    (PW)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_c[i]),
      .k_i   (k_c[i]),
      .n_i   (n_c[i]),
      .sum_i (sum_c[i]),
      .acc_i (acc_c[i]),
      .ctl_o (ctl_c[i+1]),
      .k_o   (k_c[i+1]),
      .n_o   (n_c[i+1]),
      .sum_o (sum_c[i+1]),
      .acc_o (acc_c[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (ctl_c[NW].valid) begin
      res_bit_r <= ctl_c[NW].force_one || (acc_c[NW] <= PW'(sum_c[NW]));
      res_eof_r <= ctl_c[NW].eof;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bit_r  <= res_bit_r;
      out_last_r <= res_eof_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_bit_r};
  assign out_tlast  = out_last_r;

  // a scan read is only summed right after it was issued
  a_acc_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
    acc_en_r |-> $past(state_r) == S_SCAN)
    else $error("window sum took data outside a scan");

  // the cell chain delivers only while a result is being formed
  a_chain_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_c[NW].valid |-> state_r == S_MUL || cfg_valid || $past(cfg_valid))
    else $error("product left the chain outside the multiply wait");

  // no new item is taken while a window is in progress
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_MUL) |-> !in_tready)
    else $error("item accepted during a window pass");

  // a pending result is never overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule
